### sv/u8bmp_pkg.sv
`timescale 1ns / 1ps

package u8bmp_pkg;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MIN   = 8'hC2;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD_LIMIT  = 8'hF0;
	localparam logic [7:0] E0_CONT_MIN = 8'hA0;
	localparam logic [7:0] CONT_MARK   = 8'h80;

	localparam logic [1:0] LEN_NONE  = 2'd0;
	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		logic [1:0] bytes_pending;
		logic [9:0] partial_value;
		logic       lead_was_e0;
		logic [1:0] sequence_total;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        decode_error;
		logic [1:0]  sequence_bytes;
		logic        output_last;
	} dec_result_t;

	localparam dec_state_t STATE_IDLE = '{
		bytes_pending:  2'd0,
		partial_value:  10'd0,
		lead_was_e0:    1'b0,
		sequence_total: LEN_NONE
	};

endpackage

### sv/utf8_bmp_decoder_core.sv
`timescale 1ns / 1ps

// UTF-8 to 16-bit code unit decoder for one- to three-byte sequences. One byte
// per transaction is taken on the input channel, with input_last marking the
// final byte of a string. A result comes out for every ASCII byte, for the
// byte that completes a multi-byte character, and for every error (bad lead,
// bad or overlong continuation, truncation by input_last); lead and middle
// bytes of a valid sequence give no result. On an error the offending byte is
// dropped and decoding resumes at the next lead. Surrogates pass through.
// Throughput is one byte per cycle unless the output register stalls the input:
// the byte is registered, decoded combinationally against the running sequence
// state, and the result lands in the output register. The output register
// stalls the input register only when it is full and not being taken.

module utf8_bmp_decoder_core import u8bmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        input_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        decode_error,
	output logic [1:0]  sequence_bytes,
	output logic        output_last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	logic        emit;
	dec_result_t res;
	dec_result_t res_s2;
	logic        valid_s2;
	logic        out_free;
	logic        adv_s1;

	u8bmp_step u_step (
		.cur        (state_q),
		.in_byte    (byte_s1),
		.input_last (last_s1),
		.nxt        (state_nxt),
		.emit       (emit),
		.res        (res)
	);

	assign out_free = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				valid_s2 <= adv_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= input_last;
		end
		if (out_free && adv_s1 && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign code_unit      = res_s2.code_unit;
	assign decode_error   = res_s2.decode_error;
	assign sequence_bytes = res_s2.sequence_bytes;
	assign output_last    = res_s2.output_last;

endmodule

### sv/u8bmp_step.sv
`timescale 1ns / 1ps

module u8bmp_step import u8bmp_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  in_byte,
	input  logic        input_last,
	output dec_state_t  nxt,
	output logic        emit,
	output dec_result_t res
);

	logic [7:0] payload;
	logic       cont_ok;

	always_comb begin
		payload = in_byte ^ CONT_MARK;
		cont_ok = (payload < 8'h40);
		if (cur.bytes_pending[1] && cur.lead_was_e0 && (in_byte < E0_CONT_MIN)) begin
			cont_ok = 1'b0;
		end

		nxt  = cur;
		emit = 1'b0;
		res  = '{
			code_unit:      16'd0,
			decode_error:   1'b1,
			sequence_bytes: LEN_NONE,
			output_last:    input_last
		};

		if (cur.bytes_pending == 2'd0) begin
			if (in_byte < ASCII_LIMIT) begin
				emit               = 1'b1;
				res.code_unit      = {8'd0, in_byte};
				res.decode_error   = 1'b0;
				res.sequence_bytes = LEN_ONE;
			end else if ((in_byte < LEAD2_MIN) || (in_byte >= LEAD_LIMIT) || input_last) begin
				emit = 1'b1;
				nxt  = STATE_IDLE;
			end else if (in_byte < LEAD3_MIN) begin
				nxt.bytes_pending  = 2'd1;
				nxt.partial_value  = {5'd0, in_byte[4:0]};
				nxt.lead_was_e0    = 1'b0;
				nxt.sequence_total = LEN_TWO;
			end else begin
				nxt.bytes_pending  = 2'd2;
				nxt.partial_value  = {6'd0, in_byte[3:0]};
				nxt.lead_was_e0    = (in_byte == LEAD3_MIN);
				nxt.sequence_total = LEN_THREE;
			end
		end else if (!cont_ok) begin
			emit = 1'b1;
			nxt  = STATE_IDLE;
		end else if (cur.bytes_pending[1]) begin
			if (input_last) begin
				emit = 1'b1;
				nxt  = STATE_IDLE;
			end else begin
				nxt.partial_value = {cur.partial_value[3:0], payload[5:0]};
				nxt.bytes_pending = 2'd1;
			end
		end else begin
			emit               = 1'b1;
			res.code_unit      = {cur.partial_value, payload[5:0]};
			res.decode_error   = 1'b0;
			res.sequence_bytes = cur.sequence_total;
			nxt                = STATE_IDLE;
		end
	end

endmodule

### tb/sv/utf8_bmp_decoder_chk.sv
`timescale 1ns / 1ps

module utf8_bmp_decoder_chk import u8bmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        input_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] code_unit,
	input  logic        decode_error,
	input  logic [1:0]  sequence_bytes,
	input  logic        output_last,
	input  logic        run_done,
	output int          fail_count,
	output int          awaiting,
	output int          units_checked,
	output int          errors_checked
);

	localparam logic [7:0] CONT_SPAN  = 8'h40;
	localparam int         PRINT_CAP  = 40;

	dec_state_t  seq_state = STATE_IDLE;
	dec_result_t unit_queue[$];

	initial begin
		fail_count     = 0;
		awaiting       = 0;
		units_checked  = 0;
		errors_checked = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= PRINT_CAP) begin
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// advances the sequence state by one byte; returns 1 when a result is due
	function automatic bit decode_byte(input logic [7:0] b, input logic last,
			output dec_result_t res);
		logic [7:0] payload;
		bit         ok;
		res = '0;
		res.output_last = last;
		if (seq_state.bytes_pending == 2'd0) begin
			if (b < ASCII_LIMIT) begin
				res.code_unit      = {8'h00, b};
				res.sequence_bytes = LEN_ONE;
				return 1'b1;
			end
			if (b < LEAD2_MIN || b >= LEAD_LIMIT || last) begin
				seq_state        = STATE_IDLE;
				res.decode_error = 1'b1;
				return 1'b1;
			end
			if (b < LEAD3_MIN) begin
				seq_state = '{2'd1, {5'd0, b[4:0]}, 1'b0, LEN_TWO};
			end else begin
				seq_state = '{2'd2, {6'd0, b[3:0]}, b == LEAD3_MIN, LEN_THREE};
			end
			return 1'b0;
		end
		payload = b ^ CONT_MARK;
		ok = payload < CONT_SPAN;
		if (seq_state.bytes_pending >= 2'd2 && seq_state.lead_was_e0 && b < E0_CONT_MIN) begin
			ok = 1'b0;
		end
		if (!ok || (seq_state.bytes_pending >= 2'd2 && last)) begin
			seq_state        = STATE_IDLE;
			res.decode_error = 1'b1;
			return 1'b1;
		end
		if (seq_state.bytes_pending >= 2'd2) begin
			seq_state.partial_value = {seq_state.partial_value[3:0], payload[5:0]};
			seq_state.bytes_pending = 2'd1;
			return 1'b0;
		end
		res.code_unit      = {seq_state.partial_value, payload[5:0]};
		res.sequence_bytes = seq_state.sequence_total;
		seq_state          = STATE_IDLE;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		dec_result_t got;
		dec_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{code_unit, decode_error, sequence_bytes, output_last};
				if (unit_queue.size() == 0) begin
					report_mismatch("result with none expected, code_unit", got.code_unit, 0);
				end else begin
					want = unit_queue.pop_front();
					if (got.code_unit !== want.code_unit)
						report_mismatch("code_unit", got.code_unit, want.code_unit);
					if (got.decode_error !== want.decode_error)
						report_mismatch("decode_error", got.decode_error, want.decode_error);
					if (got.sequence_bytes !== want.sequence_bytes)
						report_mismatch("sequence_bytes", got.sequence_bytes, want.sequence_bytes);
					if (got.output_last !== want.output_last)
						report_mismatch("output_last", got.output_last, want.output_last);
					units_checked++;
					if (want.decode_error) begin
						errors_checked++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (decode_byte(in_byte, input_last, want)) begin
					unit_queue.push_back(want);
				end
			end
		end
		awaiting = unit_queue.size();
	end

	always @(posedge run_done) begin
		dec_result_t want;
		while (unit_queue.size() > 0) begin
			want = unit_queue.pop_front();
			report_mismatch("result never produced, code_unit", -1, want.code_unit);
		end
		awaiting = 0;
	end

endmodule

### tb/sv/utf8_bmp_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_bmp_decoder_core_tb;
	import u8bmp_pkg::*;

	localparam int         ITEM_TARGET = 550;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 60;
	localparam int         HOLD_AFTER  = 30;
	localparam logic [7:0] LEAD2_MAX   = 8'hDF;
	localparam logic [7:0] LEAD3_MAX   = 8'hEF;
	localparam logic [7:0] CONT_MAX    = 8'hBF;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte        = 8'h00;
	logic        input_last     = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [15:0] code_unit;
	logic        decode_error;
	logic [1:0]  sequence_bytes;
	logic        output_last;
	logic        run_done       = 1'b0;
	int          fail_count;
	int          awaiting;
	int          units_checked;
	int          errors_checked;
	int          bytes_sent     = 0;
	int          cycle_count    = 0;

	// {input_last, in_byte}
	logic [8:0] directed[$] = '{
		9'h000, 9'h07F, 9'h141,
		9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
		9'h0E0, 9'h0A0, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
		9'h0ED, 9'h0A0, 9'h080,
		9'h080, 9'h0C1, 9'h0F0, 9'h0FF,
		9'h0E0, 9'h09F,
		9'h0C2, 9'h041,
		9'h0E1, 9'h0C0,
		9'h1C2,
		9'h0E1, 9'h180,
		9'h0C3, 9'h1A9
	};

	always #5 clk = ~clk;

	utf8_bmp_decoder_core i_dut (.*);

	utf8_bmp_decoder_chk i_check (.*);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = ((bytes_sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		in_byte    <= b;
		input_last <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	initial begin
		int stall;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_AFTER) begin
				stall = HOLD_CYCLES;
			end else begin
				stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		logic [7:0] seq[3];
		logic       final_last;
		int         len;
		int         cut;
		int         pick;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i][7:0], directed[i][8]);
		end

		while (bytes_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				continue;
			end
			len = $urandom_range(1, 3);
			case (len)
			1: begin
				seq[0] = 8'($urandom_range(0, ASCII_LIMIT - 1));
			end
			2: begin
				seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
			end
			default: begin
				seq[0] = ($urandom_range(0, 3) == 0) ? LEAD3_MIN :
					8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
			end
			endcase
			seq[1] = 8'($urandom_range(CONT_MARK, CONT_MAX));
			seq[2] = 8'($urandom_range(CONT_MARK, CONT_MAX));
			if (seq[0] == LEAD3_MIN) begin
				seq[1] = 8'($urandom_range(E0_CONT_MIN, CONT_MAX));
			end
			final_last = $urandom_range(0, 5) == 0;
			// broken sequences: cut short by the end flag, or a corrupted byte
			if (pick < 26 && len > 1) begin
				cut = $urandom_range(1, len - 1);
				if ($urandom_range(0, 1)) begin
					len        = cut;
					final_last = 1'b1;
				end else begin
					seq[cut] = 8'($urandom);
				end
			end
			for (int i = 0; i < len; i++) begin
				send_byte(seq[i], (i == len - 1) && final_last);
			end
		end
		in_valid <= 1'b0;

		wait (awaiting == 0);
		repeat (8) @(negedge clk);
		run_done <= 1'b1;
		@(negedge clk);
		$display("Drove %0d bytes: directed edge cases, random strings of 1-3 byte characters,",
			bytes_sent);
		$display("noise and truncated or corrupted sequences; %0d results checked, %0d errors.",
			units_checked, errors_checked);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/u8bmp_pkg.sv
sv/u8bmp_step.sv
sv/utf8_bmp_decoder_core.sv
tb/sv/utf8_bmp_decoder_chk.sv
tb/sv/utf8_bmp_decoder_core_tb.sv
